@@ sv/b2d_pkg.sv @@
// Shared types and constants for the binary-to-decimal digit converter.
// No dependencies.
`timescale 1ns / 1ps

package b2d_pkg;

  localparam int VALUE_W     = 64;
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int CHAR_W      = 6;
  localparam int CNT_W       = 5;
  localparam int CONV_STEPS  = VALUE_W;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // one queued word: the value plus the front's zero classification
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_zero;
  } item_t;

  // back-end sequencer, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

endpackage

@@ sv/b2d_front.sv @@
// Input stage: registers each accepted word and flags zero values.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0]   in_value,
  output logic                          push,
  output b2d_pkg::item_t                push_item,
  input  logic                          q_full
);

  logic           valid_r, valid_nxt;
  b2d_pkg::item_t item_r;
  logic           accept;

  assign push     = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.value   <= in_value;
      item_r.is_zero <= (in_value == '0);
    end
  end

endmodule

@@ sv/b2d_fifo.sv @@
// Short word queue between the input stage and the converter.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_fifo #(
  parameter int Depth = b2d_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b2d_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output b2d_pkg::item_t head_item,
  output logic           empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b2d_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(Depth));
  assign empty     = (cnt_r == '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

@@ sv/b2d_back.sv @@
// Converter: shift-add-3 over the binary word, leading-zero strip, then
// one digit per output word; zero values skip both. Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  b2d_pkg::item_t                head_item,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]    out_digit_char,
  output logic [b2d_pkg::CNT_W-1:0]     out_digit_count,
  output logic [b2d_pkg::CNT_W-1:0]     out_exponent,
  output logic                          out_final_digit
);

  localparam int BcdW = b2d_pkg::BCD_W;
  localparam int VW   = b2d_pkg::VALUE_W;
  localparam int CW   = b2d_pkg::CNT_W;

  b2d_pkg::back_state_t state_r, state_nxt;
  logic [VW-1:0]                  bin_r, bin_nxt;
  logic [BcdW-1:0]                bcd_r, bcd_nxt;
  logic [b2d_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [CW-1:0]                  dig_cnt_r, dig_cnt_nxt;
  logic [CW-1:0]                  left_r, left_nxt;
  logic                           ov_r, ov_nxt;
  logic [b2d_pkg::CHAR_W-1:0]     char_r, char_nxt;
  logic [CW-1:0]                  cnt_out_r, cnt_out_nxt;
  logic [CW-1:0]                  exp_r, exp_nxt;
  logic                           fin_r, fin_nxt;

  logic [BcdW-1:0] bcd_adj;
  logic [3:0]      top_nib;
  logic            out_take;

  assign top_nib  = bcd_r[BcdW-1 -: 4];
  assign out_take = ov_r && !out_stall;
  assign pop      = (state_r == b2d_pkg::ST_IDLE) && !q_empty;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2d_pkg::BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    step_nxt    = step_r;
    dig_cnt_nxt = dig_cnt_r;
    left_nxt    = left_r;
    ov_nxt      = ov_r;
    char_nxt    = char_r;
    cnt_out_nxt = cnt_out_r;
    exp_nxt     = exp_r;
    fin_nxt     = fin_r;
    unique case (state_r)
      b2d_pkg::ST_IDLE: begin
        if (!q_empty) begin
          bin_nxt  = head_item.value;
          bcd_nxt  = '0;
          step_nxt = '0;
          if (head_item.is_zero) begin
            char_nxt    = b2d_pkg::ASCII_ZERO;
            cnt_out_nxt = CW'(1);
            exp_nxt     = '0;
            fin_nxt     = 1'b1;
            left_nxt    = '0;
            ov_nxt      = 1'b1;
            state_nxt   = b2d_pkg::ST_EMIT;
          end else begin
            state_nxt = b2d_pkg::ST_CONV;
          end
        end
      end
      b2d_pkg::ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BcdW-2:0], bin_r, 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == b2d_pkg::STEP_W'(b2d_pkg::CONV_STEPS - 1)) begin
          dig_cnt_nxt = CW'(b2d_pkg::BCD_DIGITS);
          state_nxt   = b2d_pkg::ST_SKIP;
        end
      end
      b2d_pkg::ST_SKIP: begin
        // value is nonzero here, so a nonzero digit is always found
        bcd_nxt = {bcd_r[BcdW-5:0], 4'd0};
        if (top_nib == 4'd0) begin
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          char_nxt    = b2d_pkg::ASCII_ZERO | {2'b00, top_nib};
          cnt_out_nxt = dig_cnt_r;
          exp_nxt     = dig_cnt_r - 1'b1;
          fin_nxt     = (dig_cnt_r == CW'(1));
          left_nxt    = dig_cnt_r - 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = b2d_pkg::ST_EMIT;
        end
      end
      b2d_pkg::ST_EMIT: begin
        if (out_take) begin
          if (left_r == '0) begin
            ov_nxt    = 1'b0;
            state_nxt = b2d_pkg::ST_IDLE;
          end else begin
            char_nxt = b2d_pkg::ASCII_ZERO | {2'b00, top_nib};
            fin_nxt  = (left_r == CW'(1));
            left_nxt = left_r - 1'b1;
            bcd_nxt  = {bcd_r[BcdW-5:0], 4'd0};
          end
        end
      end
      default: begin
        state_nxt = b2d_pkg::ST_IDLE;
        ov_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2d_pkg::ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    step_r    <= step_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    left_r    <= left_nxt;
    char_r    <= char_nxt;
    cnt_out_r <= cnt_out_nxt;
    exp_r     <= exp_nxt;
    fin_r     <= fin_nxt;
  end

  assign out_valid       = ov_r;
  assign out_digit_char  = char_r;
  assign out_digit_count = cnt_out_r;
  assign out_exponent    = exp_r;
  assign out_final_digit = fin_r;

`ifndef SYNTHESIS
  a_valid_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == b2d_pkg::ST_EMIT)
    else $error("word shown outside emit phase");
  a_exp_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> exp_r == cnt_out_r - 1'b1)
    else $error("exponent does not match digit count");
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> fin_r == (left_r == '0))
    else $error("final marker on wrong digit");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && fin_r |=> !ov_r && state_r == b2d_pkg::ST_IDLE)
    else $error("run did not end after final digit");
`endif

endmodule

@@ sv/binary_to_decimal_digits_core.sv @@
// Unsigned 64-bit binary to ASCII decimal digits, most significant first.
// Zero values skip conversion and show a single digit; others pass through
// the 64-bit shift-add-3 loop and a leading-zero strip.
// One digit word per cycle while out_stall is low; the single shift-add-3
// loop takes no new word until the last digit of the previous one is taken.
// Reset (rst_n low, synchronous) empties the input stage, queue and converter.
`timescale 1ns / 1ps

module binary_to_decimal_digits_core #(
  parameter int QueueDepth = b2d_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]    out_digit_char,
  output logic [b2d_pkg::CNT_W-1:0]     out_digit_count,
  output logic [b2d_pkg::CNT_W-1:0]     out_exponent,
  output logic                          out_final_digit
);

  logic           push, pop, q_full, q_empty;
  b2d_pkg::item_t push_item, head_item;

  b2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  b2d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  b2d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_item       (head_item),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_char  (out_digit_char),
    .out_digit_count (out_digit_count),
    .out_exponent    (out_exponent),
    .out_final_digit (out_final_digit)
  );

endmodule
